/* design/bscs_pkg.sv */
// bscs_pkg: shared types and constants for the bucketed sorted code set unit
// field widths, command codes and the sequencer state type; no dependencies
package bscs_pkg;

   localparam int CODE_W   = 14;   // stored number width
   localparam int LETTER_W = 5;    // bucket select field width
   localparam int TOTAL_W  = 14;   // reported total count width
   localparam int BKT_CMP_W = 7;   // wide enough to compare a letter against up to 64 buckets

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH,
      ST_CMP,
      ST_SHIFT_RD,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

/* design/bucketed_sorted_code_set_unit.sv */
// bucketed_sorted_code_set_unit: top level, request sequencer, bucket fill table
// and total counter; depends on bscs_pkg and bscs_code_mem
//
//   channel    ports                                    direction
//   request    req_valid req_ready req_cmd req_letter   in
//              req_number
//   response   rsp_valid rsp_ready rsp_found            out
//              rsp_rejected rsp_total_count
//
// one request at a time; both commands binary-search the bucket of n codes, each
// probe of the registered-read code memory taking a search state and a compare
// state; an insert then opens its slot by a one-entry-a-cycle shift of the entries
// above it (no shift when the slot is at the end) before placing the code, and the
// unit passes back through idle before the next request
// reset is synchronous and clears the fill table and total at once; the code
// memory needs no clearing since only entries below a bucket's fill are read
// a new request is taken while an earlier response still waits in the output
// register; a finished request holds in the done state until that register frees
module bucketed_sorted_code_set_unit
   import bscs_pkg::*;
#(
   parameter int BUCKET_DEPTH = 512,
   parameter int BUCKETS      = 26
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic [CODE_W-1:0]   req_number,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic                rsp_rejected,
   output logic [TOTAL_W-1:0]  rsp_total_count
);

   localparam int MEM_DEPTH = BUCKETS * BUCKET_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int BIDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
   localparam int POS_W     = $clog2(BUCKET_DEPTH);

   // sequencer state and per-request context
   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [CODE_W-1:0]   key_ff, key_in;
   logic [BIDX_W-1:0]   bidx_ff, bidx_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [FILL_W-1:0]   n_ff, n_in;
   logic [FILL_W-1:0]   lo_ff, lo_in;
   logic [FILL_W-1:0]   hi_ff, hi_in;
   logic [POS_W-1:0]    mid_ff, mid_in;
   logic [POS_W-1:0]    j_ff, j_in;
   logic                found_ff, found_in;
   logic                rej_ff, rej_in;

   // bucket fill table and running total
   logic [FILL_W-1:0]   fill_ff [BUCKETS];
   logic [TOTAL_W-1:0]  total_ff;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic                rsp_rejected_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;

   // memory port
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [CODE_W-1:0]   mem_wr_data;
   logic [CODE_W-1:0]   mem_rd_data;

   // request decode
   logic                letter_ok;
   logic [BIDX_W-1:0]   req_bidx;
   logic [FILL_W-1:0]   req_fill;
   logic                req_full;
   logic                take_req;
   logic                place_now;
   logic                rsp_load;
   logic                srch_more;
   logic [POS_W-1:0]    lo_pos;

   assign letter_ok = {{(BKT_CMP_W - LETTER_W){1'b0}}, req_letter} < BKT_CMP_W'(BUCKETS);
   assign req_bidx  = BIDX_W'(req_letter);
   assign req_fill  = letter_ok ? fill_ff[req_bidx] : '0;
   assign req_full  = (req_fill == FILL_W'(BUCKET_DEPTH));
   assign take_req  = req_valid && req_ready;
   assign srch_more = (lo_ff < hi_ff);
   assign lo_pos    = POS_W'(lo_ff);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign place_now = (state_ff == ST_PLACE);

   bscs_code_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_code_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               if (!letter_ok || ((req_cmd == CMD_INSERT) && req_full)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            if (srch_more) begin
               state_in = ST_CMP;
            end else if (cmd_ff == CMD_LOOKUP) begin
               state_in = ST_DONE;
            end else if (lo_ff == n_ff) begin
               state_in = ST_PLACE;   // slot at the end, nothing to move
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_CMP:      state_in = ST_SRCH;
         ST_SHIFT_RD: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (j_ff == lo_pos) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE:    state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake and memory port
   always_comb begin
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SRCH: begin
            // probe the midpoint of the open range
            mem_rd_en   = srch_more;
            mem_rd_addr = base_ff + ADDR_W'(mid_in);
         end
         ST_SHIFT_RD: begin
            // fetch the last entry of the bucket
            mem_rd_en   = 1'b1;
            mem_rd_addr = base_ff + ADDR_W'(n_ff - FILL_W'(1));
         end
         ST_SHIFT: begin
            // move entry j up one slot while fetching entry j-1
            mem_wr_en   = 1'b1;
            mem_wr_addr = base_ff + ADDR_W'(j_ff) + ADDR_W'(1);
            mem_wr_data = mem_rd_data;
            mem_rd_en   = (j_ff != lo_pos);
            mem_rd_addr = base_ff + ADDR_W'(j_ff - POS_W'(1));
         end
         ST_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = base_ff + ADDR_W'(lo_pos);
            mem_wr_data = key_ff;
         end
         ST_CMP, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // request context and search datapath
   always_comb begin
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      bidx_in  = bidx_ff;
      base_in  = base_ff;
      n_in     = n_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      j_in     = j_ff;
      found_in = found_ff;
      rej_in   = rej_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               cmd_in   = req_cmd;
               key_in   = req_number;
               bidx_in  = req_bidx;
               base_in  = ADDR_W'(req_bidx) * ADDR_W'(BUCKET_DEPTH);
               n_in     = req_fill;
               lo_in    = '0;
               hi_in    = req_fill;
               found_in = 1'b0;
               rej_in   = (req_cmd == CMD_INSERT) && (!letter_ok || req_full);
            end
         end
         ST_SRCH: begin
            mid_in = POS_W'(lo_ff + ((hi_ff - lo_ff) >> 1));
         end
         ST_CMP: begin
            // upper-bound search; any equal probe proves presence on a lookup
            if (mem_rd_data <= key_ff) begin
               lo_in = FILL_W'(mid_ff) + FILL_W'(1);
            end else begin
               hi_in = FILL_W'(mid_ff);
            end
            if ((cmd_ff == CMD_LOOKUP) && (mem_rd_data == key_ff)) begin
               found_in = 1'b1;
            end
         end
         ST_SHIFT_RD: begin
            j_in = POS_W'(n_ff - FILL_W'(1));
         end
         ST_SHIFT: begin
            if (j_ff != lo_pos) begin
               j_in = j_ff - POS_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      bidx_ff  <= bidx_in;
      base_ff  <= base_in;
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      j_ff     <= j_in;
      found_ff <= found_in;
      rej_ff   <= rej_in;
   end

   // fill table and total bump when the new code lands
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUCKETS; i++) begin
            fill_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (place_now) begin
         fill_ff[bidx_ff] <= fill_ff[bidx_ff] + FILL_W'(1);
         total_ff         <= total_ff + TOTAL_W'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff    <= found_ff;
         rsp_rejected_ff <= rej_ff;
         rsp_total_ff    <= total_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_rejected    = rsp_rejected_ff;
   assign rsp_total_count = rsp_total_ff;

endmodule

/* design/bscs_code_mem.sv */
// bscs_code_mem: code store, one write port and one registered read port
// depends on bscs_pkg for the code width
module bscs_code_mem
   import bscs_pkg::*;
#(
   parameter int DEPTH  = 13312,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CODE_W-1:0] wr_data,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
